[hdl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ROBB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

[hdl/robb_pkg.sv]
`default_nettype none
package robb_pkg;

	// field widths
	localparam int POS_W = 20;
	localparam int VEC_W = 16;
	localparam int DIST_W = 25;
	localparam int AXIS_CFG_W = 48;
	localparam int POS_CFG_W = 60;
	localparam int CFG_IDX_W = 3;

	// datapath widths
	localparam int DELTA_W = 21;
	localparam int PE_W = 37;
	localparam int PF_W = 32;
	localparam int E_W = 39;
	localparam int F_W = 34;
	localparam int EXT_W = 34;
	localparam int NS_W = 40;
	localparam int NUM_W = 52;
	localparam int DEN_W = 32;
	localparam int QUO_W = 34;
	localparam int T_W = 36;
	localparam int FRAC_SHIFT = 14;

	// constants
	localparam logic signed [T_W-1:0] T_LIMIT = 36'sd25600000;
	localparam logic [DEN_W-1:0] PARALLEL_EPS = 32'd268435;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX = 3'd5;

	// reset values
	localparam logic [AXIS_CFG_W-1:0] AXIS_X_RST = 48'h0000_0000_4000;
	localparam logic [AXIS_CFG_W-1:0] AXIS_Y_RST = 48'h0000_4000_0000;
	localparam logic [AXIS_CFG_W-1:0] AXIS_Z_RST = 48'h4000_0000_0000;

	// divider is an input register plus one step per quotient bit
	localparam int DIV_LAT = QUO_W + 1;
	// request to result strobe
	localparam int LATENCY = DIV_LAT + 10;

	// valid bit and per-axis flags that ride alongside the dividers
	typedef struct packed {
		logic       valid;
		logic [2:0] par;
		logic [2:0] pmiss;
		logic [2:0] neg_lo;
		logic [2:0] neg_hi;
	} side_t;

	typedef struct packed {
		logic                  miss;
		logic signed [T_W-1:0] tmin;
		logic signed [T_W-1:0] tmax;
	} ival_t;

endpackage
`default_nettype wire

[hdl/robb_div.sv]
`default_nettype none
module robb_div (
	input  wire logic                       clk,
	input  wire logic [robb_pkg::NUM_W-1:0] num,
	input  wire logic [robb_pkg::DEN_W-1:0] den,
	output logic [robb_pkg::QUO_W-1:0]      quo
);
	import robb_pkg::*;

	// upper numerator bits that form the starting remainder
	localparam int HEAD_W = NUM_W - QUO_W;

	logic [DEN_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] low_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];

	// capture operands; the head is below any divisor that takes this path
	always_ff @(posedge clk) begin
		rem_s[0] <= DEN_W'(num[NUM_W-1 -: HEAD_W]);
		low_s[0] <= num[QUO_W-1:0];
		quo_s[0] <= '0;
		den_s[0] <= den;
	end

	// one restoring step per stage, msb of quotient first
	for (genvar j = 1; j <= QUO_W; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[j-1], low_s[j-1][QUO_W-1]};
			diff = trial - {1'b0, den_s[j-1]};
			ge = trial >= {1'b0, den_s[j-1]};
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_s[j] <= {low_s[j-1][QUO_W-2:0], 1'b0};
			quo_s[j] <= {quo_s[j-1][QUO_W-2:0], ge};
			den_s[j] <= den_s[j-1];
		end
	end

	assign quo = quo_s[QUO_W];

endmodule
`default_nettype wire

[hdl/ray_obb_intersection_top.sv]
`default_nettype none
// Ray against oriented box slab test. One ray is taken on every clock (busy never rises)
// and its result strobes on done once it has passed four stages of projection math, the
// six bit-per-stage dividers (34 quotient bits plus an input register) and six stages
// of interval logic. The result is not held: the receiver must take it in the cycle done
// is high. Box registers may be written only while no ray is in flight.
module ray_obb_intersection_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [robb_pkg::POS_W-1:0]     ray_origin_x,
	input  wire logic signed [robb_pkg::POS_W-1:0]     ray_origin_y,
	input  wire logic signed [robb_pkg::POS_W-1:0]     ray_origin_z,
	input  wire logic signed [robb_pkg::VEC_W-1:0]     ray_dir_x,
	input  wire logic signed [robb_pkg::VEC_W-1:0]     ray_dir_y,
	input  wire logic signed [robb_pkg::VEC_W-1:0]     ray_dir_z,
	output logic                                       done,
	output logic                                       hit,
	output logic [robb_pkg::DIST_W-1:0]                hit_distance,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [robb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [robb_pkg::POS_CFG_W-1:0]        cfg_data
);
	import robb_pkg::*;

	`include "assert_macros.svh"

	logic [AXIS_CFG_W-1:0] axis_q [0:2];
	logic [POS_CFG_W-1:0]  center_q;
	logic [POS_CFG_W-1:0]  min_q;
	logic [POS_CFG_W-1:0]  max_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] <= AXIS_X_RST;
			axis_q[1] <= AXIS_Y_RST;
			axis_q[2] <= AXIS_Z_RST;
			center_q <= '0;
			min_q <= '0;
			max_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_AXIS_X: axis_q[0] <= cfg_data[AXIS_CFG_W-1:0];
				CFG_AXIS_Y: axis_q[1] <= cfg_data[AXIS_CFG_W-1:0];
				CFG_AXIS_Z: axis_q[2] <= cfg_data[AXIS_CFG_W-1:0];
				CFG_CENTER: center_q <= cfg_data;
				CFG_MIN: min_q <= cfg_data;
				CFG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8, valid_s9;

	// stage 1: offset from origin to box center
	logic signed [DELTA_W-1:0] delta_s1 [0:2];
	logic signed [VEC_W-1:0]   dir_s1 [0:2];
	logic signed [POS_W-1:0]   org [0:2];
	logic signed [VEC_W-1:0]   dir_in [0:2];

	always_comb begin
		org[0] = ray_origin_x;
		org[1] = ray_origin_y;
		org[2] = ray_origin_z;
		dir_in[0] = ray_dir_x;
		dir_in[1] = ray_dir_y;
		dir_in[2] = ray_dir_z;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			delta_s1[k] <= DELTA_W'($signed(center_q[POS_W*k +: POS_W]))
				- DELTA_W'(org[k]);
			dir_s1[k] <= dir_in[k];
		end
	end

	// stage 2: axis products
	logic signed [PE_W-1:0] pe_s2 [0:2][0:2];
	logic signed [PF_W-1:0] pf_s2 [0:2][0:2];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				pe_s2[i][k] <= PE_W'($signed(axis_q[i][VEC_W*k +: VEC_W]))
					* PE_W'(delta_s1[k]);
				pf_s2[i][k] <= PF_W'($signed(axis_q[i][VEC_W*k +: VEC_W]))
					* PF_W'(dir_s1[k]);
			end
		end
	end

	// stage 3: dot products
	logic signed [E_W-1:0] e_s3 [0:2];
	logic signed [F_W-1:0] f_s3 [0:2];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e_s3[i] <= E_W'(pe_s2[i][0]) + E_W'(pe_s2[i][1]) + E_W'(pe_s2[i][2]);
			f_s3[i] <= F_W'(pf_s2[i][0]) + F_W'(pf_s2[i][1]) + F_W'(pf_s2[i][2]);
		end
	end

	// stage 4: slab numerators and parallel check
	logic signed [EXT_W-1:0] lo_ext [0:2];
	logic signed [EXT_W-1:0] hi_ext [0:2];
	logic [F_W-1:0]          f_mag [0:2];
	logic signed [NS_W-1:0]  nlo_s4 [0:2];
	logic signed [NS_W-1:0]  nhi_s4 [0:2];
	logic signed [F_W-1:0]   f_s4 [0:2];
	logic [2:0]              par_s4;
	logic [2:0]              pmiss_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo_ext[i] = {min_q[POS_W*i +: POS_W], FRAC_SHIFT'(0)};
			hi_ext[i] = {max_q[POS_W*i +: POS_W], FRAC_SHIFT'(0)};
			f_mag[i] = f_s3[i][F_W-1] ? F_W'(-f_s3[i]) : F_W'(f_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nlo_s4[i] <= NS_W'(e_s3[i]) + NS_W'(lo_ext[i]);
			nhi_s4[i] <= NS_W'(e_s3[i]) + NS_W'(hi_ext[i]);
			f_s4[i] <= f_s3[i];
			par_s4[i] <= f_mag[i] <= F_W'(PARALLEL_EPS);
			pmiss_s4[i] <= (E_W'(lo_ext[i]) > e_s3[i]) || (E_W'(hi_ext[i]) < e_s3[i]);
		end
	end

	// divider operands, magnitudes only
	logic [NS_W-1:0]  nlo_mag [0:2];
	logic [NS_W-1:0]  nhi_mag [0:2];
	logic [F_W-1:0]   den_mag [0:2];
	logic [QUO_W-1:0] qlo [0:2];
	logic [QUO_W-1:0] qhi [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nlo_mag[i] = nlo_s4[i][NS_W-1] ? NS_W'(-nlo_s4[i]) : NS_W'(nlo_s4[i]);
			nhi_mag[i] = nhi_s4[i][NS_W-1] ? NS_W'(-nhi_s4[i]) : NS_W'(nhi_s4[i]);
			den_mag[i] = f_s4[i][F_W-1] ? F_W'(-f_s4[i]) : F_W'(f_s4[i]);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		robb_div u_div_lo (
			.clk (clk),
			.num ({nlo_mag[i][NUM_W-FRAC_SHIFT-1:0], FRAC_SHIFT'(0)}),
			.den (den_mag[i][DEN_W-1:0]),
			.quo (qlo[i])
		);
		robb_div u_div_hi (
			.clk (clk),
			.num ({nhi_mag[i][NUM_W-FRAC_SHIFT-1:0], FRAC_SHIFT'(0)}),
			.den (den_mag[i][DEN_W-1:0]),
			.quo (qhi[i])
		);
	end

	// flags delayed to match the dividers
	side_t side_in;
	side_t side_d [0:DIV_LAT-1];

	always_comb begin
		side_in.valid = valid_s4;
		side_in.par = par_s4;
		side_in.pmiss = pmiss_s4;
		for (int i = 0; i < 3; i++) begin
			side_in.neg_lo[i] = nlo_s4[i][NS_W-1] ^ f_s4[i][F_W-1];
			side_in.neg_hi[i] = nhi_s4[i][NS_W-1] ^ f_s4[i][F_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIV_LAT; d++) begin
				side_d[d] <= '0;
			end
		end else begin
			side_d[0] <= side_in;
			for (int d = 1; d < DIV_LAT; d++) begin
				side_d[d] <= side_d[d-1];
			end
		end
	end

	side_t side_out;
	assign side_out = side_d[DIV_LAT-1];

	// stage 5: signed distances
	logic signed [T_W-1:0] ta_s5 [0:2];
	logic signed [T_W-1:0] tb_s5 [0:2];
	logic [2:0]            par_s5, pmiss_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ta_s5[i] <= side_out.neg_lo[i] ? -T_W'(qlo[i]) : T_W'(qlo[i]);
			tb_s5[i] <= side_out.neg_hi[i] ? -T_W'(qhi[i]) : T_W'(qhi[i]);
		end
		par_s5 <= side_out.par;
		pmiss_s5 <= side_out.pmiss;
	end

	// stage 6: order each pair
	logic signed [T_W-1:0] t1_s6 [0:2];
	logic signed [T_W-1:0] t2_s6 [0:2];
	logic [2:0]            par_s6, pmiss_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t1_s6[i] <= (ta_s5[i] > tb_s5[i]) ? tb_s5[i] : ta_s5[i];
			t2_s6[i] <= (ta_s5[i] > tb_s5[i]) ? ta_s5[i] : tb_s5[i];
		end
		par_s6 <= par_s5;
		pmiss_s6 <= pmiss_s5;
	end

	// narrow the interval by one axis
	function automatic ival_t narrow(input ival_t cur, input logic signed [T_W-1:0] t1,
			input logic signed [T_W-1:0] t2, input logic par, input logic pmiss);
		ival_t nxt;
		nxt = cur;
		if (par) begin
			nxt.miss = cur.miss | pmiss;
		end else begin
			if (t2 < cur.tmax) begin
				nxt.tmax = t2;
			end
			if (t1 > cur.tmin) begin
				nxt.tmin = t1;
			end
			nxt.miss = cur.miss | (nxt.tmax < nxt.tmin);
		end
		return nxt;
	endfunction

	ival_t ival_init;
	ival_t ival_s7, ival_s8, ival_s9;
	logic signed [T_W-1:0] t1_s7 [1:2];
	logic signed [T_W-1:0] t2_s7 [1:2];
	logic signed [T_W-1:0] t1_s8, t2_s8;
	logic [2:1]            par_s7, pmiss_s7;
	logic                  par_s8, pmiss_s8;

	always_comb begin
		ival_init.miss = 1'b0;
		ival_init.tmin = '0;
		ival_init.tmax = T_LIMIT;
	end

	// stages 7 to 9: one axis each
	always_ff @(posedge clk) begin
		ival_s7 <= narrow(ival_init, t1_s6[0], t2_s6[0], par_s6[0], pmiss_s6[0]);
		t1_s7[1] <= t1_s6[1];
		t2_s7[1] <= t2_s6[1];
		t1_s7[2] <= t1_s6[2];
		t2_s7[2] <= t2_s6[2];
		par_s7 <= par_s6[2:1];
		pmiss_s7 <= pmiss_s6[2:1];

		ival_s8 <= narrow(ival_s7, t1_s7[1], t2_s7[1], par_s7[1], pmiss_s7[1]);
		t1_s8 <= t1_s7[2];
		t2_s8 <= t2_s7[2];
		par_s8 <= par_s7[2];
		pmiss_s8 <= pmiss_s7[2];

		ival_s9 <= narrow(ival_s8, t1_s8, t2_s8, par_s8, pmiss_s8);
	end

	// valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			done <= 1'b0;
			hit <= 1'b0;
			hit_distance <= '0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= side_out.valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			done <= valid_s9;
			hit <= valid_s9 && !ival_s9.miss;
			hit_distance <= (valid_s9 && !ival_s9.miss) ? ival_s9.tmin[DIST_W-1:0] : '0;
		end
	end

	// checks
	`ROBB_ASSERT(a_fixed_latency, start && !busy |-> ##LATENCY done,
		"result strobe missing at fixed latency")
	`ROBB_ASSERT(a_hit_with_done, hit |-> done, "hit without result strobe")
	`ROBB_ASSERT(a_dist_needs_hit, hit_distance != '0 |-> hit,
		"distance nonzero on a miss")
	`ROBB_ASSERT(a_dist_limit, hit |-> (T_W'(hit_distance) <= T_LIMIT),
		"distance beyond interval limit")

endmodule
`default_nettype wire
